// File: rtl/core/fsub_pkg.sv
// Package for the first_substring_match block: input kind codes, result status
// codes, the operation type and the queue entry that joins front and back.
// Depends on nothing.
`default_nettype none

package fsub_pkg;

   localparam int unsigned POS_W       = 32;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] KIND_PATTERN = 2'd0;
   localparam logic [1:0] KIND_TEXT    = 2'd1;
   localparam logic [1:0] KIND_CLEAR   = 2'd2;

   localparam logic [1:0] STATUS_FOUND     = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   typedef enum logic [1:0] {
      OP_PATTERN = 2'd0,
      OP_TEXT    = 2'd1,
      OP_CLEAR   = 2'd2
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       last;
   } entry_type;

endpackage

`default_nettype wire

// File: rtl/core/first_substring_match.sv
// Top level of the streaming first-occurrence substring search.
// Instantiates fsub_front, fsub_queue and fsub_back; depends on fsub_pkg.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   req_kind, req_byte_value, req_last
//   rsp_      out        rsp_valid/rsp_stall   rsp_status, rsp_position
//
// One transaction per clock cycle is accepted and executed while no stall holds the flow; every text byte updates
// all partial-match bits in the back end within that cycle.
// A taken request passes through the queue before its result is registered in the response register.
// Reset is synchronous and empties the queue, the pattern and the search state.
// A stalled response holds the back end; the four-entry queue then fills, and
// req_stall rises only when it is full.
`default_nettype none

module first_substring_match #(
   parameter int unsigned NEEDLE_MAX = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_position
);
   import fsub_pkg::*;

   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   fsub_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_byte_value (req_byte_value),
      .req_last       (req_last),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   fsub_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   fsub_back #(
      .NEEDLE_MAX (NEEDLE_MAX)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_entry   (head_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position)
   );

endmodule

`default_nettype wire

// File: rtl/core/fsub_front.sv
// Front end: accepts request transactions, decodes the kind into an operation
// and pushes it into the queue. Unused kinds are accepted and dropped.
// Depends on fsub_pkg.
`default_nettype none

module fsub_front (
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_kind,
   input  wire logic [7:0]          req_byte_value,
   input  wire logic                req_last,
   input  wire logic                queue_full,
   output logic                     push,
   output fsub_pkg::entry_type      push_entry
);
   import fsub_pkg::*;

   logic   known;
   op_type op;

   always_comb begin
      known = 1'b1;
      op    = OP_TEXT;
      unique case (req_kind)
         KIND_PATTERN: op = OP_PATTERN;
         KIND_TEXT:    op = OP_TEXT;
         KIND_CLEAR:   op = OP_CLEAR;
         default:      known = 1'b0;
      endcase
   end

   assign req_stall       = queue_full;
   assign push            = req_valid && !queue_full && known;
   assign push_entry.op   = op;
   assign push_entry.data = req_byte_value;
   assign push_entry.last = req_last;

endmodule

`default_nettype wire

// File: rtl/core/fsub_queue.sv
// Short first-in first-out queue of decoded operations between front and back.
// Depends on fsub_pkg.
`default_nettype none

module fsub_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire fsub_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     head_valid,
   output fsub_pkg::entry_type      head_entry
);
   import fsub_pkg::*;

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/fsub_back.sv
// Back end: holds the pattern and search state, executes one queued operation
// per cycle when not stalled and keeps the result in the response register.
// Depends on fsub_pkg.
`default_nettype none

module fsub_back #(
   parameter int unsigned NEEDLE_MAX = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire fsub_pkg::entry_type head_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [fsub_pkg::POS_W-1:0] rsp_position
);
   import fsub_pkg::*;

   localparam int unsigned LEN_W = $clog2(NEEDLE_MAX + 1);
   localparam int unsigned IDX_W = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

   logic [7:0]            store_ff [NEEDLE_MAX];
   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  overflow_ff, overflow_in;
   logic                  open_ff, open_in;
   logic [NEEDLE_MAX-1:0] bits_ff, bits_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  reported_ff, reported_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            status_ff, status_in;
   logic [POS_W-1:0]      position_ff, position_in;

   logic [NEEDLE_MAX-1:0] eq;
   logic [NEEDLE_MAX-1:0] advanced;
   logic [LEN_W-1:0]      len_m1;
   logic [LEN_W-1:0]      wr_len;
   logic                  store_we;
   logic                  hit;
   logic [POS_W-1:0]      start;
   logic                  emit;

   // The back end moves when the response register is empty or being drained.
   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   // Every stored byte is compared with the text byte at once.
   always_comb begin
      for (int i = 0; i < NEEDLE_MAX; i++) begin
         eq[i] = (LEN_W'(i) < len_ff) && (store_ff[i] == head_entry.data);
      end
   end

   assign advanced = ((bits_ff << 1) | NEEDLE_MAX'(1)) & eq;
   assign len_m1   = len_ff - 1'b1;
   assign wr_len   = open_ff ? len_ff : '0;
   assign start    = (pos_ff == POS_MAX) ? POS_MAX : pos_ff - POS_W'(len_m1);

   always_comb begin
      len_in       = len_ff;
      overflow_in  = overflow_ff;
      open_in      = open_ff;
      bits_in      = bits_ff;
      pos_in       = pos_ff;
      reported_in  = reported_ff;
      store_we     = 1'b0;
      hit          = 1'b0;
      emit         = 1'b0;
      status_in    = status_ff;
      position_in  = position_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         unique case (head_entry.op)
            OP_PATTERN: begin
               open_in = !head_entry.last;
               if (!open_ff) begin
                  overflow_in = 1'b0;
               end
               if (wr_len < LEN_W'(NEEDLE_MAX)) begin
                  store_we = 1'b1;
                  len_in   = wr_len + 1'b1;
               end else begin
                  len_in      = wr_len;
                  overflow_in = 1'b1;
               end
               bits_in     = '0;
               pos_in      = '0;
               reported_in = 1'b0;
            end
            OP_CLEAR: begin
               len_in      = '0;
               overflow_in = 1'b0;
               open_in     = 1'b0;
               bits_in     = '0;
               pos_in      = '0;
               reported_in = 1'b0;
            end
            OP_TEXT: begin
               open_in = 1'b0;
               if (overflow_ff) begin
                  if (head_entry.last) begin
                     emit        = 1'b1;
                     status_in   = STATUS_OVERFLOW;
                     position_in = '0;
                  end
               end else if (!reported_ff) begin
                  if (len_ff == '0) begin
                     hit         = 1'b1;
                     position_in = '0;
                  end else begin
                     bits_in = advanced;
                     if (advanced[len_m1[IDX_W-1:0]]) begin
                        hit         = 1'b1;
                        position_in = start;
                     end
                  end
                  if (hit) begin
                     emit        = 1'b1;
                     reported_in = 1'b1;
                     status_in   = STATUS_FOUND;
                  end else if (head_entry.last) begin
                     emit        = 1'b1;
                     status_in   = STATUS_NOT_FOUND;
                     position_in = '0;
                  end
               end
               if (pos_ff != POS_MAX) begin
                  pos_in = pos_ff + 1'b1;
               end
               if (head_entry.last) begin
                  bits_in     = '0;
                  pos_in      = '0;
                  reported_in = 1'b0;
               end
            end
            default: ;
         endcase
         if (emit) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         overflow_ff  <= 1'b0;
         open_ff      <= 1'b0;
         bits_ff      <= '0;
         pos_ff       <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         overflow_ff  <= overflow_in;
         open_ff      <= open_in;
         bits_ff      <= bits_in;
         pos_ff       <= pos_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      position_ff <= position_in;
      if (store_we) begin
         store_ff[wr_len[IDX_W-1:0]] <= head_entry.data;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_position = position_ff;

endmodule

`default_nettype wire

// File: rtl/core/first_substring_match_checker.sv
// Port-level checker for first_substring_match and the bind that attaches it.
// Depends on fsub_pkg.
`default_nettype none

module first_substring_match_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic [31:0] rsp_position
);
   import fsub_pkg::*;

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_position))
      else $error("stalled response changed");

   // Only a match carries a nonzero position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_FOUND |-> rsp_position == '0)
      else $error("nonzero position without a match");

   // Reset leaves no response pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   // A response does not rise straight out of reset; a request must be accepted first.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset))
      else $error("response appeared right after reset");

endmodule

bind first_substring_match first_substring_match_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_position (rsp_position)
);

`default_nettype wire

// File: test/first_substring_match_tb.sv
// Self-checking testbench for first_substring_match: directed searches, pattern overflow,
// a long response stall and random pattern/text streams, all checked against a predictor.
// Depends on fsub_pkg and the first_substring_match RTL.
module first_substring_match_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fsub_pkg::*;

   localparam int unsigned NEEDLE_MAX   = 32;
   localparam int          RESET_CYCLES = 11;
   localparam int          TAIL_CYCLES  = 8;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam logic [1:0]  KIND_UNUSED  = 2'd3;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] position;
   } match_report_type;

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind       = KIND_TEXT;
   logic [7:0]  req_byte_value = 8'h00;
   logic        req_last       = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_position;

   // Search state mirrored from the block.
   logic [7:0]            pattern_bytes [NEEDLE_MAX];
   int unsigned           pattern_len     = 0;
   logic                  pattern_over    = 1'b0;
   logic                  pattern_loading = 1'b0;
   logic [NEEDLE_MAX-1:0] prefix_hits     = '0;
   logic [31:0]           text_index      = '0;
   logic                  reported        = 1'b0;

   match_report_type match_reports [$];
   logic [7:0]    letters [3];
   bit            idle_on      = 1'b1;
   int            hold_cycles  = 0;
   int            items_sent   = 0;
   int            results_seen = 0;
   int            failures     = 0;
   int            cycle_count  = 0;

   first_substring_match #(.NEEDLE_MAX(NEEDLE_MAX)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_byte_value (req_byte_value),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int draw_gap();
      if (!idle_on) return 0;
      return $urandom_range(0, 8);
   endfunction

   function automatic logic [7:0] pick_letter();
      if ($urandom_range(0, 7) == 0) return 8'($urandom);
      return letters[$urandom_range(0, 2)];
   endfunction

   function automatic void rearm_search();
      prefix_hits = '0;
      text_index  = '0;
      reported    = 1'b0;
   endfunction

   function automatic void push_report(logic [1:0] status, logic [31:0] position);
      match_report_type r;
      r.status   = status;
      r.position = position;
      match_reports = {match_reports, r};
   endfunction

   // Advances the mirrored search by one accepted transaction.
   function automatic void step_search(logic [1:0] kind, logic [7:0] value, logic fin);
      logic [NEEDLE_MAX-1:0] same;
      logic                  hit;
      logic [31:0]           start;
      same  = '0;
      hit   = 1'b0;
      start = '0;
      case (kind)
         KIND_PATTERN: begin
            if (!pattern_loading) begin
               pattern_len     = 0;
               pattern_over    = 1'b0;
               pattern_loading = 1'b1;
            end
            if (pattern_len < NEEDLE_MAX) begin
               pattern_bytes[pattern_len] = value;
               pattern_len++;
            end else begin
               pattern_over = 1'b1;
            end
            if (fin) pattern_loading = 1'b0;
            rearm_search();
         end
         KIND_CLEAR: begin
            pattern_len     = 0;
            pattern_over    = 1'b0;
            pattern_loading = 1'b0;
            rearm_search();
         end
         KIND_TEXT: begin
            pattern_loading = 1'b0;
            if (pattern_over) begin
               if (fin) push_report(STATUS_OVERFLOW, '0);
            end else if (!reported) begin
               if (pattern_len == 0) begin
                  hit = 1'b1;
               end else begin
                  for (int i = 0; i < NEEDLE_MAX; i++)
                     same[i] = (i < pattern_len) && (pattern_bytes[i] == value);
                  prefix_hits = ((prefix_hits << 1) | 1) & same;
                  if (prefix_hits[pattern_len-1]) begin
                     hit   = 1'b1;
                     start = (text_index == POS_MAX) ? POS_MAX
                             : text_index - 32'(pattern_len - 1);
                  end
               end
               if (hit) begin
                  reported = 1'b1;
                  push_report(STATUS_FOUND, start);
               end else if (fin) begin
                  push_report(STATUS_NOT_FOUND, '0);
               end
            end
            if (text_index != POS_MAX) text_index++;
            if (fin) rearm_search();
         end
         default: ;
      endcase
   endfunction

   // Offers one request transaction and holds it until the block takes it.
   // Valid stays high afterwards so that a back-to-back transaction needs no toggle.
   task automatic send_item(input logic [1:0] kind, input logic [7:0] value, input logic fin);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_byte_value <= value;
      req_last       <= fin;
      do @(posedge clock); while (req_stall);
      step_search(kind, value, fin);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (match_reports.size() != 0);
   endtask

   task automatic send_pattern(input int len, input bit close);
      for (int i = 0; i < len; i++)
         send_item(KIND_PATTERN, pick_letter(), close && (i == len - 1));
   endtask

   // Text with occasional stray transactions that break or disturb the search.
   task automatic send_text(input int len);
      int r;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r == 0)
            send_item(KIND_PATTERN, pick_letter(), 1'($urandom));
         else if (r == 1)
            send_item(KIND_UNUSED, 8'($urandom), 1'($urandom));
         else if (r == 2)
            send_item(KIND_CLEAR, 8'($urandom), 1'($urandom));
         send_item(KIND_TEXT, pick_letter(), i == len - 1);
      end
   endtask

   task automatic test_empty_pattern();
      send_item(KIND_TEXT, 8'h00, 1'b0);
      send_item(KIND_TEXT, 8'hFF, 1'b1);
      wait_drained();
   endtask

   task automatic test_directed_matches();
      send_item(KIND_PATTERN, 8'h00, 1'b0);
      send_item(KIND_PATTERN, 8'hFF, 1'b1);
      send_item(KIND_TEXT, 8'hFF, 1'b0);
      send_item(KIND_TEXT, 8'h00, 1'b0);
      send_item(KIND_TEXT, 8'hFF, 1'b0);
      send_item(KIND_TEXT, 8'h00, 1'b1);
      // A pattern longer than the text can never complete.
      send_item(KIND_PATTERN, 8'h41, 1'b0);
      send_item(KIND_PATTERN, 8'h42, 1'b0);
      send_item(KIND_PATTERN, 8'h43, 1'b1);
      send_item(KIND_TEXT, 8'h41, 1'b0);
      send_item(KIND_TEXT, 8'h42, 1'b1);
      send_item(KIND_UNUSED, 8'hFF, 1'b1);
      send_item(KIND_TEXT, 8'h41, 1'b0);
      send_item(KIND_TEXT, 8'h42, 1'b0);
      send_item(KIND_TEXT, 8'h43, 1'b1);
      // The first text byte closes a pattern that was left open.
      send_item(KIND_PATTERN, 8'h10, 1'b0);
      send_item(KIND_TEXT, 8'h10, 1'b1);
      // A pattern byte in the middle of a text restarts the search.
      send_item(KIND_PATTERN, 8'h20, 1'b1);
      send_item(KIND_TEXT, 8'h20, 1'b0);
      send_item(KIND_PATTERN, 8'h20, 1'b1);
      send_item(KIND_TEXT, 8'h21, 1'b0);
      send_item(KIND_TEXT, 8'h20, 1'b1);
      send_item(KIND_CLEAR, 8'hFF, 1'b0);
      send_item(KIND_TEXT, 8'h55, 1'b1);
      wait_drained();
   endtask

   task automatic test_overflow();
      for (int s = 0; s < 4; s++) begin
         idle_on = (s != 1);
         foreach (letters[k]) letters[k] = 8'($urandom);
         send_pattern(NEEDLE_MAX + $urandom_range(1, 3), 1'b1);
         repeat (2) send_text($urandom_range(1, 5));
      end
      // A pattern that fills the store exactly still matches.
      idle_on = 1'b1;
      for (int i = 0; i < NEEDLE_MAX; i++)
         send_item(KIND_PATTERN, 8'hA5, i == NEEDLE_MAX - 1);
      for (int i = 0; i <= NEEDLE_MAX; i++)
         send_item(KIND_TEXT, 8'hA5, i == NEEDLE_MAX);
      wait_drained();
   endtask

   // Every text byte below gives a result, so a long response stall fills the block.
   task automatic test_backpressure();
      idle_on = 1'b0;
      hold_cycles = 100;
      send_item(KIND_CLEAR, 8'h00, 1'b0);
      repeat (20) send_item(KIND_TEXT, 8'($urandom), 1'b1);
      wait_drained();
      idle_on = 1'b1;
   endtask

   task automatic test_random_search(input int count);
      int first;
      int r;
      first = items_sent;
      while (items_sent - first < count) begin
         idle_on = ($urandom_range(0, 3) != 0);
         foreach (letters[k]) letters[k] = 8'($urandom);
         r = $urandom_range(0, 19);
         if (r == 0)
            send_item(KIND_CLEAR, 8'($urandom), 1'($urandom));
         else if (r == 1)
            send_pattern($urandom_range(5, NEEDLE_MAX), 1'b1);
         else
            send_pattern($urandom_range(1, 4), $urandom_range(0, 9) != 0);
         repeat ($urandom_range(1, 3))
            send_text(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12));
      end
      wait_drained();
   endtask

   // Response side: a random stall before each result, and a long hold when asked.
   initial begin
      int n;
      forever begin
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         n = draw_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid && hold_cycles == 0);
      end
   end

   always @(posedge clock) begin : check_results
      match_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (match_reports.size() == 0) begin
            failures++;
            $error("result with none pending: status %0d position %0d",
                   rsp_status, rsp_position);
         end else begin
            want = match_reports.pop_front();
            if (rsp_status !== want.status) begin
               failures++;
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
            end
            if (rsp_position !== want.position) begin
               failures++;
               $error("position: expected %0d, actual %0d", want.position, rsp_position);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("first_substring_match_tb: FAIL");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_empty_pattern();
      test_directed_matches();
      test_overflow();
      test_backpressure();
      test_random_search(360);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Ran %0d request and %0d result transactions in %0d cycles:", items_sent,
               results_seen, cycle_count);
      $display("directed cases, pattern overflow, a long response stall, random searches.");
      if (failures == 0)
         $display("first_substring_match_tb: PASS");
      else
         $display("first_substring_match_tb: FAIL");
      $finish;
   end

endmodule
